// ===== src/lease_token_arbiter_assert.svh =====
// Assertion macros for the lease token arbiter.
`ifndef LEASE_TOKEN_ARBITER_ASSERT_SVH
`define LEASE_TOKEN_ARBITER_ASSERT_SVH

// Same-cycle implication, clocked on clk, held off during reset.
`define LTA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lease_token_arbiter: assertion failed");

// Next-cycle implication, clocked on clk, held off during reset.
`define LTA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lease_token_arbiter: assertion failed");

`endif

// ===== src/lta_pkg.sv =====
// Shared types and constants of the lease token arbiter.
`default_nettype none

package lta_pkg;

  // Parameter defaults
  localparam int SLOTS_DEF     = 8;
  localparam int ID_BITS_DEF   = 16;
  localparam int TIME_BITS_DEF = 32;

  // Field and register widths
  localparam int ACTION_W   = 2;
  localparam int OUTCOME_W  = 3;
  localparam int HOLDERS_W  = 4;
  localparam int CAP_W      = 4;
  localparam int HOLD_W     = 16;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_HOLDERS = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS  = 4'd1;

  // Register reset values
  localparam logic [CAP_W-1:0]  MAX_HOLDERS_RST = 4'd2;
  localparam logic [HOLD_W-1:0] HOLD_TICKS_RST  = 16'd250;

  // Action codes; the unused code decodes as a tick
  localparam logic [ACTION_W-1:0] ACT_REQUEST = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_RETURN  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_TICK    = 2'd2;

  typedef enum logic [OUTCOME_W-1:0] {
    OC_HELD     = 3'd0,
    OC_FREE     = 3'd1,
    OC_PREEMPT  = 3'd2,
    OC_DENIED   = 3'd3,
    OC_RELEASED = 3'd4,
    OC_NOT_HELD = 3'd5,
    OC_TICKED   = 3'd6
  } outcome_t;

  // Verdict on one list entry
  typedef struct packed {
    logic hit;   // entry id equals the key
    logic take;  // entry is eligible and at least as old as the best so far
  } judge_t;

endpackage

`default_nettype wire

// ===== src/lta_judge.sv =====
// Per-entry evaluation: id match, age and preemption candidacy.
`default_nettype none

module lta_judge #(
  parameter int ID_BITS   = lta_pkg::ID_BITS_DEF,
  parameter int TIME_BITS = lta_pkg::TIME_BITS_DEF
) (
  input  wire logic [ID_BITS-1:0]        ent_id,
  input  wire logic [TIME_BITS-1:0]      ent_time,
  input  wire logic [ID_BITS-1:0]        key,
  input  wire logic [TIME_BITS-1:0]      now,
  input  wire logic [lta_pkg::HOLD_W-1:0] hold,
  input  wire logic                      found,
  input  wire logic [TIME_BITS-1:0]      best_age,
  output lta_pkg::judge_t                res,
  output logic [TIME_BITS-1:0]           age
);

  logic eligible;

  // Wraps modulo the time width
  assign age      = now - ent_time;
  assign eligible = (age >= TIME_BITS'(hold));

  // Later entries win ties
  assign res.take = eligible && (!found || (age >= best_age));
  assign res.hit  = (ent_id == key);

endmodule

`default_nettype wire

// ===== src/lease_token_arbiter.sv =====
// Lease token arbiter top level: list memory, scan sequencer, handshakes.
//
// Grants up to max_holders concurrent tokens to requester ids. The holders
// form an ordered, compacted list of {id, grant time} entries kept in a
// single-port-read memory with a registered read port. A request or a
// return with a nonzero id scans the list one entry per cycle: with n >= 1
// holders a transaction, once accepted, issues n reads, evaluates the last
// entry read, lets the sequencer see the read pipeline empty and commits;
// only then is a new input taken. Ticks, null ids and an empty list skip
// the scan. The memory read port, stepped once per cycle, paces the scan;
// the commit also waits while the output register still holds a result
// that out_ready has not taken. A return compacts the list in place
// during its scan; a request may append or overwrite one entry at commit.
// The result sits in an output register, so the next input transaction is
// accepted while a finished result still waits for out_ready. The list
// needs no clearing after reset: entries at or beyond the holder count are
// never read. Configuration (max_holders, hold_ticks) is written through
// cfg_we/cfg_index/cfg_data; the user must do so only while the block is
// idle, which the block itself does not enforce.
`default_nettype none

module lease_token_arbiter #(
  parameter int SLOTS     = lta_pkg::SLOTS_DEF,
  parameter int ID_BITS   = lta_pkg::ID_BITS_DEF,
  parameter int TIME_BITS = lta_pkg::TIME_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // input channel
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [lta_pkg::ACTION_W-1:0]    in_action,
  input  wire logic [ID_BITS-1:0]              in_requester_id,
  // result channel
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [lta_pkg::OUTCOME_W-1:0]        out_outcome,
  output logic                                 out_granted,
  output logic [ID_BITS-1:0]                   out_evicted_id,
  output logic [lta_pkg::HOLDERS_W-1:0]        out_holders,
  // configuration
  input  wire logic                            cfg_we,
  input  wire logic [lta_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [lta_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int ENT_W = ID_BITS + TIME_BITS;
  localparam int CAP_W = lta_pkg::CAP_W;
  localparam int CMP_W = ((CNT_W > CAP_W) ? CNT_W : CAP_W) + 1;
  localparam int HW    = lta_pkg::HOLDERS_W;
  localparam int OW    = lta_pkg::OUTCOME_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    OP_REQ,
    OP_RET,
    OP_TICK
  } op_t;

  // ---------------------------------------------------------------------
  // Control and datapath registers
  // ---------------------------------------------------------------------
  state_t                     state_r, state_nxt;
  op_t                        op_r, op_nxt;
  logic [ID_BITS-1:0]         key_r, key_nxt;
  logic [CNT_W-1:0]           count_r, count_nxt;
  logic [TIME_BITS-1:0]       time_r, time_nxt;
  logic [CAP_W-1:0]           max_holders_r, max_holders_nxt;
  logic [lta_pkg::HOLD_W-1:0] hold_r, hold_nxt;

  logic [CNT_W-1:0]           scan_len_r, scan_len_nxt;
  logic [CNT_W-1:0]           rd_idx_r, rd_idx_nxt;
  logic                       dv_r, dv_nxt;
  logic [AW-1:0]              d_idx_r, d_idx_nxt;
  logic [CNT_W-1:0]           w_r, w_nxt;
  logic                       hit_r, hit_nxt;
  logic                       found_r, found_nxt;
  logic [AW-1:0]              best_idx_r, best_idx_nxt;
  logic [TIME_BITS-1:0]       best_age_r, best_age_nxt;
  logic [ID_BITS-1:0]         best_id_r, best_id_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic [OW-1:0]              out_outcome_r, out_outcome_nxt;
  logic                       out_granted_r, out_granted_nxt;
  logic [ID_BITS-1:0]         out_evicted_r, out_evicted_nxt;
  logic [HW-1:0]              out_holders_r, out_holders_nxt;

  // ---------------------------------------------------------------------
  // List memory: {id, grant time}, one read and one write per cycle
  // ---------------------------------------------------------------------
  logic [ENT_W-1:0] mem [SLOTS];
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic [ENT_W-1:0] rdata_r;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [ENT_W-1:0] wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // Entry evaluation on the data returned by the memory
  logic [ID_BITS-1:0]   ent_id;
  logic [TIME_BITS-1:0] ent_time;
  logic [TIME_BITS-1:0] ent_age;
  lta_pkg::judge_t      verdict;

  assign ent_id   = rdata_r[ENT_W-1:TIME_BITS];
  assign ent_time = rdata_r[TIME_BITS-1:0];

  lta_judge #(
    .ID_BITS   (ID_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_judge (
    .ent_id   (ent_id),
    .ent_time (ent_time),
    .key      (key_r),
    .now      (time_r),
    .hold     (hold_r),
    .found    (found_r),
    .best_age (best_age_r),
    .res      (verdict),
    .age      (ent_age)
  );

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  logic in_fire;
  logic out_free;
  logic cap_free;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // Room for an append: below both the configured limit and the slot count
  assign cap_free = (CMP_W'(count_r) < CMP_W'(max_holders_r)) &&
                    (CMP_W'(count_r) < CMP_W'(SLOTS));

  always_comb begin
    state_nxt       = state_r;
    op_nxt          = op_r;
    key_nxt         = key_r;
    count_nxt       = count_r;
    time_nxt        = time_r;
    max_holders_nxt = max_holders_r;
    hold_nxt        = hold_r;
    scan_len_nxt    = scan_len_r;
    rd_idx_nxt      = rd_idx_r;
    dv_nxt          = 1'b0;
    d_idx_nxt       = d_idx_r;
    w_nxt           = w_r;
    hit_nxt         = hit_r;
    found_nxt       = found_r;
    best_idx_nxt    = best_idx_r;
    best_age_nxt    = best_age_r;
    best_id_nxt     = best_id_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_outcome_nxt = out_outcome_r;
    out_granted_nxt = out_granted_r;
    out_evicted_nxt = out_evicted_r;
    out_holders_nxt = out_holders_r;
    rd_en           = 1'b0;
    rd_addr         = rd_idx_r[AW-1:0];
    wr_en           = 1'b0;
    wr_addr         = w_r[AW-1:0];
    wr_data         = rdata_r;

    // Configuration writes; indexes beyond the list are dropped
    if (cfg_we) begin
      unique case (cfg_index)
        lta_pkg::REG_MAX_HOLDERS: max_holders_nxt = cfg_data[CAP_W-1:0];
        lta_pkg::REG_HOLD_TICKS:  hold_nxt        = cfg_data[lta_pkg::HOLD_W-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_action)
            lta_pkg::ACT_REQUEST: op_nxt = OP_REQ;
            lta_pkg::ACT_RETURN:  op_nxt = OP_RET;
            default:              op_nxt = OP_TICK;
          endcase
          key_nxt    = in_requester_id;
          rd_idx_nxt = '0;
          w_nxt      = '0;
          hit_nxt    = 1'b0;
          found_nxt  = 1'b0;
          // Ticks and null ids skip the scan
          if ((in_action == lta_pkg::ACT_REQUEST || in_action == lta_pkg::ACT_RETURN) &&
              (in_requester_id != '0)) begin
            scan_len_nxt = count_r;
          end else begin
            scan_len_nxt = '0;
          end
          state_nxt = S_SCAN;
        end
      end

      S_SCAN: begin
        // Issue one read per cycle
        if (rd_idx_r < scan_len_r) begin
          rd_en      = 1'b1;
          rd_idx_nxt = rd_idx_r + CNT_W'(1);
          dv_nxt     = 1'b1;
          d_idx_nxt  = rd_idx_r[AW-1:0];
        end
        // Evaluate the entry read in the previous cycle
        if (dv_r) begin
          if (op_r == OP_REQ) begin
            if (verdict.hit) begin
              hit_nxt = 1'b1;
            end
            if (verdict.take) begin
              found_nxt    = 1'b1;
              best_idx_nxt = d_idx_r;
              best_age_nxt = ent_age;
              best_id_nxt  = ent_id;
            end
          end else if (!verdict.hit) begin
            // Compact: write survivors back at the write pointer
            wr_en   = 1'b1;
            wr_addr = w_r[AW-1:0];
            wr_data = rdata_r;
            w_nxt   = w_r + CNT_W'(1);
          end
        end
        if ((rd_idx_r == scan_len_r) && !dv_r) begin
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        // Hold the commit until the output register is free
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_granted_nxt = 1'b0;
          out_evicted_nxt = '0;
          out_outcome_nxt = lta_pkg::OC_TICKED;
          unique case (op_r)
            OP_REQ: begin
              if (key_r == '0) begin
                out_outcome_nxt = lta_pkg::OC_DENIED;
              end else if (hit_r) begin
                out_outcome_nxt = lta_pkg::OC_HELD;
                out_granted_nxt = 1'b1;
              end else if (cap_free) begin
                wr_en           = 1'b1;
                wr_addr         = count_r[AW-1:0];
                wr_data         = {key_r, time_r};
                count_nxt       = count_r + CNT_W'(1);
                out_outcome_nxt = lta_pkg::OC_FREE;
                out_granted_nxt = 1'b1;
              end else if (found_r) begin
                wr_en           = 1'b1;
                wr_addr         = best_idx_r;
                wr_data         = {key_r, time_r};
                out_outcome_nxt = lta_pkg::OC_PREEMPT;
                out_granted_nxt = 1'b1;
                out_evicted_nxt = best_id_r;
              end else begin
                out_outcome_nxt = lta_pkg::OC_DENIED;
              end
            end
            OP_RET: begin
              if (key_r == '0) begin
                out_outcome_nxt = lta_pkg::OC_NOT_HELD;
              end else begin
                count_nxt       = w_r;
                out_outcome_nxt = (w_r != count_r) ? lta_pkg::OC_RELEASED
                                                   : lta_pkg::OC_NOT_HELD;
              end
            end
            default: begin
              time_nxt        = time_r + TIME_BITS'(1);
              out_outcome_nxt = lta_pkg::OC_TICKED;
            end
          endcase
          out_holders_nxt = HW'(count_nxt);
          state_nxt       = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      count_r       <= '0;
      time_r        <= '0;
      max_holders_r <= lta_pkg::MAX_HOLDERS_RST;
      hold_r        <= lta_pkg::HOLD_TICKS_RST;
      dv_r          <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      count_r       <= count_nxt;
      time_r        <= time_nxt;
      max_holders_r <= max_holders_nxt;
      hold_r        <= hold_nxt;
      dv_r          <= dv_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    op_r          <= op_nxt;
    key_r         <= key_nxt;
    scan_len_r    <= scan_len_nxt;
    rd_idx_r      <= rd_idx_nxt;
    d_idx_r       <= d_idx_nxt;
    w_r           <= w_nxt;
    hit_r         <= hit_nxt;
    found_r       <= found_nxt;
    best_idx_r    <= best_idx_nxt;
    best_age_r    <= best_age_nxt;
    best_id_r     <= best_id_nxt;
    out_outcome_r <= out_outcome_nxt;
    out_granted_r <= out_granted_nxt;
    out_evicted_r <= out_evicted_nxt;
    out_holders_r <= out_holders_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_outcome    = out_outcome_r;
  assign out_granted    = out_granted_r;
  assign out_evicted_id = out_evicted_r;
  assign out_holders    = out_holders_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  logic grant_code;

  // Outcomes that leave the requester holding a token
  assign grant_code = (out_outcome_r == lta_pkg::OC_HELD) ||
                      (out_outcome_r == lta_pkg::OC_FREE) ||
                      (out_outcome_r == lta_pkg::OC_PREEMPT);

  `include "lease_token_arbiter_assert.svh"

  `LTA_ASSERT_IMP(a_count_range, 1'b1, count_r <= CNT_W'(SLOTS))
  `LTA_ASSERT_NXT(a_accept_scans, in_valid && in_ready, state_r == S_SCAN)
  `LTA_ASSERT_IMP(a_grant_codes, out_valid_r && out_granted_r, grant_code)
  `LTA_ASSERT_IMP(a_evict_only_preempt, out_valid_r && (out_evicted_r != '0), out_outcome_r == lta_pkg::OC_PREEMPT)

endmodule

`default_nettype wire
